// File: rtl/sipu_pkg.sv
package sipu_pkg;

    // Number of coordinate fields packed into one input item.
    localparam int unsigned IN_FIELDS = 8;

    // Number of coordinate fields packed into the result tdata.
    localparam int unsigned OUT_DATA_FIELDS = 2;

endpackage

// File: rtl/segment_intersection_point_unit.sv
// Channel | Direction | tdata (lowest bit up)                     | tuser
// s_      | in        | a_start_x a_start_y a_end_x a_end_y        | -
//         |           | b_start_x b_start_y b_end_x b_end_y        |
// m_      | out       | cross_x cross_y, zero padded to bytes      | hit
//
// One item can be accepted every cycle while the pipeline is not stalled;
// the divider takes one quotient bit per pipeline stage, which sets the
// depth.
// aresetn is synchronous and active low; it clears the valid bits only.
// Each stage holds while the stage after it is full and stalled, so bubbles
// are squeezed out and nothing is lost or repeated.
module segment_intersection_point_unit
    import sipu_pkg::*;
#(
    parameter int COORD_BITS = 16
) (
    input  logic                                       aclk,
    input  logic                                       aresetn,
    input  logic                                       s_tvalid,
    output logic                                       s_tready,
    // a_start_x, a_start_y, a_end_x, a_end_y, b_start_x, b_start_y, b_end_x, b_end_y
    input  logic [IN_FIELDS*COORD_BITS-1:0]            s_tdata,
    output logic                                       m_tvalid,
    input  logic                                       m_tready,
    // cross_x, cross_y, zero padding
    output logic [((OUT_DATA_FIELDS*COORD_BITS+7)/8)*8-1:0] m_tdata,
    // hit
    output logic                                       m_tuser
);

    localparam int N     = COORD_BITS;
    localparam int OUT_W = ((OUT_DATA_FIELDS*N + 7) / 8) * 8;
    localparam int D     = N + 1;          // coordinate differences
    localparam int P     = 2*N + 2;        // difference products
    localparam int S     = 2*N + 3;        // denom and num
    localparam int M     = 3*N + 4;        // num times a direction
    localparam int Q     = N + 2;          // quotient bits kept
    localparam int W     = S + Q;          // shifted divisor
    localparam int CW    = IN_FIELDS*N;
    localparam int NST   = Q + 6;          // pipeline stages

    // Stage control.
    logic [NST-1:0] vld_reg;
    logic [NST-1:0] vld_next;
    logic [NST:0]   en;

    // Stage advance chain: a stage loads when it is empty or its
    // successor moves on.
    always_comb begin
        en[NST] = m_tready;
        for (int k = NST-1; k >= 0; k--) begin
            en[k] = !vld_reg[k] || en[k+1];
        end
        for (int k = 0; k < NST; k++) begin
            if (en[k]) begin
                vld_next[k] = (k == 0) ? s_tvalid : vld_reg[(k == 0) ? 0 : k-1];
            end else begin
                vld_next[k] = vld_reg[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    assign s_tready = en[0];
    assign m_tvalid = vld_reg[NST-1];

    // Coordinates travel with each item.
    logic [CW-1:0] crd_reg [NST-1];

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            crd_reg[0] <= s_tdata;
        end
    end

    for (genvar k = 1; k < NST-1; k++) begin : g_crd
        always_ff @(posedge aclk) begin
            if (en[k]) begin
                crd_reg[k] <= crd_reg[k-1];
            end
        end
    end

    // Stage 0: direction and offset differences.
    logic signed [N-1:0] in_c [IN_FIELDS];
    for (genvar f = 0; f < IN_FIELDS; f++) begin : g_in
        assign in_c[f] = s_tdata[f*N +: N];
    end

    logic signed [D-1:0] dax_reg, day_reg, dbx_reg, dby_reg, ex_reg, ey_reg;

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            dax_reg <= D'(in_c[2]) - D'(in_c[0]);
            day_reg <= D'(in_c[3]) - D'(in_c[1]);
            dbx_reg <= D'(in_c[6]) - D'(in_c[4]);
            dby_reg <= D'(in_c[7]) - D'(in_c[5]);
            ex_reg  <= D'(in_c[4]) - D'(in_c[0]);
            ey_reg  <= D'(in_c[5]) - D'(in_c[1]);
        end
    end

    // Stage 1: the four cross products.
    logic signed [P-1:0] pa_reg, pb_reg, pc_reg, pd_reg;
    logic signed [D-1:0] dax1_reg, day1_reg;

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            pa_reg   <= P'(dax_reg) * P'(dby_reg);
            pb_reg   <= P'(day_reg) * P'(dbx_reg);
            pc_reg   <= P'(ex_reg) * P'(dby_reg);
            pd_reg   <= P'(ey_reg) * P'(dbx_reg);
            dax1_reg <= dax_reg;
            day1_reg <= day_reg;
        end
    end

    // Stage 2: denominator and numerator.
    logic signed [S-1:0] den_reg, num_reg;
    logic signed [D-1:0] dax2_reg, day2_reg;

    always_ff @(posedge aclk) begin
        if (en[2]) begin
            den_reg  <= S'(pa_reg) - S'(pb_reg);
            num_reg  <= S'(pc_reg) - S'(pd_reg);
            dax2_reg <= dax1_reg;
            day2_reg <= day1_reg;
        end
    end

    // Stage 3: dividends for x and y.
    logic signed [M-1:0] nx_reg, ny_reg;
    logic signed [S-1:0] den3_reg;

    always_ff @(posedge aclk) begin
        if (en[3]) begin
            nx_reg   <= M'(num_reg) * M'(dax2_reg);
            ny_reg   <= M'(num_reg) * M'(day2_reg);
            den3_reg <= den_reg;
        end
    end

    // Stage 4: magnitudes, quotient signs and the range screen. A quotient
    // of 2^Q or more lies far beyond either segment and is a miss, as is a zero denominator.
    logic [M-1:0] nxm, nym;
    logic [S-1:0] dm;
    logic [W-1:0] dlim;
    logic         miss4;

    always_comb begin
        nxm   = nx_reg[M-1] ? M'(-nx_reg) : M'(nx_reg);
        nym   = ny_reg[M-1] ? M'(-ny_reg) : M'(ny_reg);
        dm    = den3_reg[S-1] ? S'(-den3_reg) : S'(den3_reg);
        dlim  = W'(dm) << Q;
        miss4 = (den3_reg == '0) || (W'(nxm) >= dlim) || (W'(nym) >= dlim);
    end

    logic [M-1:0] remx4_reg, remy4_reg;
    logic [S-1:0] dm4_reg;
    logic         sgx4_reg, sgy4_reg, miss4_reg;

    always_ff @(posedge aclk) begin
        if (en[4]) begin
            remx4_reg <= nxm;
            remy4_reg <= nym;
            dm4_reg   <= dm;
            sgx4_reg  <= nx_reg[M-1] ^ den3_reg[S-1];
            sgy4_reg  <= ny_reg[M-1] ^ den3_reg[S-1];
            miss4_reg <= miss4;
        end
    end

    // Divider: one restoring step per stage, most significant bit first.
    logic [M-1:0] remx_reg [Q];
    logic [M-1:0] remy_reg [Q];
    logic [Q-1:0] qx_reg   [Q];
    logic [Q-1:0] qy_reg   [Q];
    logic [S-1:0] dmd_reg  [Q];
    logic         sgx_reg  [Q];
    logic         sgy_reg  [Q];
    logic         miss_reg [Q];

    for (genvar j = 0; j < Q; j++) begin : g_div
        localparam int BIT = Q - 1 - j;
        logic [M-1:0] rx_in, ry_in;
        logic [Q-1:0] qx_in, qy_in;
        logic [S-1:0] d_in;
        logic         sx_in, sy_in, ms_in;
        logic [W-1:0] sh;
        logic         gx, gy;

        if (j == 0) begin : g_first
            assign rx_in = remx4_reg;
            assign ry_in = remy4_reg;
            assign qx_in = '0;
            assign qy_in = '0;
            assign d_in  = dm4_reg;
            assign sx_in = sgx4_reg;
            assign sy_in = sgy4_reg;
            assign ms_in = miss4_reg;
        end else begin : g_next
            assign rx_in = remx_reg[j-1];
            assign ry_in = remy_reg[j-1];
            assign qx_in = qx_reg[j-1];
            assign qy_in = qy_reg[j-1];
            assign d_in  = dmd_reg[j-1];
            assign sx_in = sgx_reg[j-1];
            assign sy_in = sgy_reg[j-1];
            assign ms_in = miss_reg[j-1];
        end

        assign sh = W'(d_in) << BIT;
        assign gx = W'(rx_in) >= sh;
        assign gy = W'(ry_in) >= sh;

        always_ff @(posedge aclk) begin
            if (en[5+j]) begin
                remx_reg[j]    <= gx ? rx_in - sh[M-1:0] : rx_in;
                remy_reg[j]    <= gy ? ry_in - sh[M-1:0] : ry_in;
                qx_reg[j]      <= qx_in | (Q'(gx) << BIT);
                qy_reg[j]      <= qy_in | (Q'(gy) << BIT);
                dmd_reg[j]     <= d_in;
                sgx_reg[j]     <= sx_in;
                sgy_reg[j]     <= sy_in;
                miss_reg[j]    <= ms_in;
            end
        end
    end

    // Final stage: signed offsets, the point and the bounds test.
    logic [CW-1:0]        fc;
    logic signed [N+3:0]  xa0, ya0, xa1, ya1, xb0, yb0, xb1, yb1;
    logic signed [N+3:0]  ox, oy, px, py;
    logic                 in_x, in_y, hit;

    function automatic logic between(input logic signed [N+3:0] v,
                                     input logic signed [N+3:0] p,
                                     input logic signed [N+3:0] q);
        logic signed [N+3:0] lo;
        logic signed [N+3:0] hi;
        lo = (p < q) ? p : q;
        hi = (p > q) ? p : q;
        return (v >= lo) && (v <= hi);
    endfunction

    always_comb begin
        fc   = crd_reg[NST-2];
        xa0  = (N+4)'($signed(fc[0*N +: N]));
        ya0  = (N+4)'($signed(fc[1*N +: N]));
        xa1  = (N+4)'($signed(fc[2*N +: N]));
        ya1  = (N+4)'($signed(fc[3*N +: N]));
        xb0  = (N+4)'($signed(fc[4*N +: N]));
        yb0  = (N+4)'($signed(fc[5*N +: N]));
        xb1  = (N+4)'($signed(fc[6*N +: N]));
        yb1  = (N+4)'($signed(fc[7*N +: N]));
        ox   = sgx_reg[Q-1] ? -$signed((N+4)'(qx_reg[Q-1])) : $signed((N+4)'(qx_reg[Q-1]));
        oy   = sgy_reg[Q-1] ? -$signed((N+4)'(qy_reg[Q-1])) : $signed((N+4)'(qy_reg[Q-1]));
        px   = xa0 + ox;
        py   = ya0 + oy;
        in_x = between(px, xa0, xa1) && between(px, xb0, xb1);
        in_y = between(py, ya0, ya1) && between(py, yb0, yb1);
        hit  = !miss_reg[Q-1] && in_x && in_y;
    end

    logic [OUT_W-1:0] out_data_reg;
    logic             out_hit_reg;

    always_ff @(posedge aclk) begin
        if (en[NST-1]) begin
            out_hit_reg  <= hit;
            out_data_reg <= hit ? OUT_W'({py[N-1:0], px[N-1:0]}) : '0;
        end
    end

    assign m_tdata = out_data_reg;
    assign m_tuser = out_hit_reg;

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 100ps

module tb_top
    import sipu_pkg::*;
();

    localparam int CB = 16;
    localparam int LATENCY = CB + 8;
    localparam longint FAR_LIMIT = 64'd1 << 40;

    typedef logic signed [CB-1:0] coord_t;

    typedef struct packed {
        coord_t by1, bx1, by0, bx0, ay1, ax1, ay0, ax0;
    } seg_pair_t;

    typedef struct packed {
        logic   hit;
        coord_t cx;
        coord_t cy;
    } crossing_t;

    // A directed row: the segment pair and, where known at a glance, the result.
    typedef struct {
        seg_pair_t pair;
        logic      known;
        crossing_t want;
    } directed_row_t;

    logic aclk;
    logic aresetn;
    logic s_tvalid;
    logic s_tready;
    logic [IN_FIELDS*CB-1:0] s_tdata;
    logic m_tvalid;
    logic m_tready;
    logic [((OUT_DATA_FIELDS*CB+7)/8)*8-1:0] m_tdata;
    logic m_tuser;

    crossing_t pending_crossings[$];
    int errors;

    segment_intersection_point_unit #(.COORD_BITS(CB)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Truncating signed quotient; reports false when the magnitude is far out.
    function automatic bit trunc_quotient(input logic signed [127:0] n,
                                          input logic signed [127:0] d,
                                          output longint q);
        logic [127:0] an, ad, uq;
        an = n[127] ? -n : n;
        ad = d[127] ? -d : d;
        uq = an / ad;
        if (uq > FAR_LIMIT) return 0;
        q = (n[127] != d[127]) ? -longint'(uq) : longint'(uq);
        return 1;
    endfunction

    function automatic bit in_range(input longint v, input longint p, input longint q);
        return v >= ((p < q) ? p : q) && v <= ((p > q) ? p : q);
    endfunction

    // Intersection of the two extended lines, offsets truncated toward zero, bounded by both segments.
    function automatic crossing_t intersect_segments(input seg_pair_t s);
        logic signed [127:0] dax, day, dbx, dby, denom, num;
        longint ox, oy, px, py;
        crossing_t r;
        r = '{1'b0, '0, '0};
        dax = s.ax1 - s.ax0;
        day = s.ay1 - s.ay0;
        dbx = s.bx1 - s.bx0;
        dby = s.by1 - s.by0;
        denom = dax * dby - day * dbx;
        if (denom == 0) return r;
        num = (128'(signed'(s.bx0)) - s.ax0) * dby - (128'(signed'(s.by0)) - s.ay0) * dbx;
        if (trunc_quotient(num * dax, denom, ox) && trunc_quotient(num * day, denom, oy)) begin
            px = longint'(s.ax0) + ox;
            py = longint'(s.ay0) + oy;
            if (in_range(px, s.ax0, s.ax1) && in_range(px, s.bx0, s.bx1) &&
                in_range(py, s.ay0, s.ay1) && in_range(py, s.by0, s.by1)) begin
                r.hit = 1'b1;
                r.cx = px[CB-1:0];
                r.cy = py[CB-1:0];
            end
        end
        return r;
    endfunction

    // Drive one item, with a random gap before each new burst, and wait for acceptance.
    int burst_left;
    task automatic send_pair(input seg_pair_t p);
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge aclk);
            burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(30, 80)
                                                   : $urandom_range(1, 10);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= p;
        pending_crossings = {pending_crossings, intersect_segments(p)};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    function automatic coord_t rand_coord();
        case ($urandom_range(0, 5))
            0: return coord_t'($urandom_range(0, 16)) - 16'sd8;
            1: return 16'sh7fff - coord_t'($urandom_range(0, 3));
            2: return 16'sh8000 + coord_t'($urandom_range(0, 3));
            3: return coord_t'($urandom_range(0, 4095)) - 16'sd2048;
            default: return coord_t'($urandom);
        endcase
    endfunction

    // Mostly pairs built to cross near a chosen point, the rest parallel pairs or loose noise.
    function automatic seg_pair_t rand_pair();
        seg_pair_t p;
        int cx, cy, sp;
        p = {rand_coord(), rand_coord(), rand_coord(), rand_coord(),
             rand_coord(), rand_coord(), rand_coord(), rand_coord()};
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: begin
                sp = $urandom_range(0, 3) == 0 ? 30000 : $urandom_range(4, 4000);
                cx = int'($urandom_range(0, 60000)) - 30000;
                cy = int'($urandom_range(0, 60000)) - 30000;
                p.ax0 = coord_t'(cx - int'($urandom_range(0, sp)));
                p.ax1 = coord_t'(cx + int'($urandom_range(0, sp)));
                p.ay0 = coord_t'(cy - int'($urandom_range(0, sp)));
                p.ay1 = coord_t'(cy + int'($urandom_range(0, sp)));
                p.bx0 = coord_t'(cx - int'($urandom_range(0, sp)));
                p.bx1 = coord_t'(cx + int'($urandom_range(0, sp)));
                p.by0 = coord_t'(cy + int'($urandom_range(0, sp)));
                p.by1 = coord_t'(cy - int'($urandom_range(0, sp)));
            end
            6: begin
                // Parallel: B is A shifted.
                p.bx0 = p.ax0 + 16'sd5;
                p.by0 = p.ay0;
                p.bx1 = p.ax1 + 16'sd5;
                p.by1 = p.ay1;
            end
            default: ;
        endcase
        return p;
    endfunction

    // Receiver stall pattern, independent of the sender.
    initial begin
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if ($urandom_range(0, 50) == 0) begin
                m_tready <= 1'b1;
                repeat ($urandom_range(20, 60)) @(negedge aclk);
            end else begin
                case ($urandom_range(0, 3))
                    0: m_tready <= 1'b1;
                    1: m_tready <= ($urandom_range(0, 3) != 0);
                    2: m_tready <= ($urandom_range(0, 1) != 0);
                    default: m_tready <= ($urandom_range(0, 4) == 0);
                endcase
            end
        end
    end

    // Compare each accepted result with the oldest expectation.
    always @(posedge aclk) begin
        crossing_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_crossings.size() == 0) begin
                $display("%0t: unexpected result hit=%b x=%h y=%h", $time, m_tuser,
                         m_tdata[CB-1:0], m_tdata[2*CB-1:CB]);
                errors++;
            end else begin
                e = pending_crossings.pop_front();
                if (m_tuser !== e.hit) begin
                    $display("%0t: hit expected %b actual %b", $time, e.hit, m_tuser);
                    errors++;
                end
                if (m_tdata[CB-1:0] !== e.cx) begin
                    $display("%0t: cross_x expected %h actual %h", $time, e.cx, m_tdata[CB-1:0]);
                    errors++;
                end
                if (m_tdata[2*CB-1:CB] !== e.cy) begin
                    $display("%0t: cross_y expected %h actual %h", $time, e.cy,
                             m_tdata[2*CB-1:CB]);
                    errors++;
                end
            end
        end
    end

    // Main stimulus: directed table, then random pairs.
    initial begin
        directed_row_t rows[14];
        crossing_t miss, got;
        seg_pair_t p;
        int n;
        miss = '{1'b0, '0, '0};
        errors = 0;
        burst_left = 0;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // X crossing at the origin.
        rows[0] = '{'{ax0: -16'sd100, ay0: -16'sd100, ax1: 16'sd100, ay1: 16'sd100,
                      bx0: 16'sd100, by0: -16'sd100, bx1: -16'sd100, by1: 16'sd100},
                    1'b1, '{1'b1, 16'sd0, 16'sd0}};
        // Parallel lines.
        rows[1] = '{'{ax0: 16'sd0, ay0: 16'sd0, ax1: 16'sd10, ay1: 16'sd10,
                      bx0: 16'sd5, by0: 16'sd0, bx1: 16'sd15, by1: 16'sd10},
                    1'b1, miss};
        // Coincident lines.
        rows[2] = '{'{ax0: 16'sd0, ay0: 16'sd0, ax1: 16'sd10, ay1: 16'sd10,
                      bx0: 16'sd20, by0: 16'sd20, bx1: 16'sd30, by1: 16'sd30},
                    1'b1, miss};
        // Both vertical.
        rows[3] = '{'{ax0: 16'sd5, ay0: 16'sd0, ax1: 16'sd5, ay1: 16'sd100,
                      bx0: 16'sd9, by0: 16'sd0, bx1: 16'sd9, by1: 16'sd100},
                    1'b1, miss};
        // Degenerate point segment A.
        rows[4] = '{'{ax0: 16'sd7, ay0: 16'sd7, ax1: 16'sd7, ay1: 16'sd7,
                      bx0: 16'sd0, by0: 16'sd0, bx1: 16'sd100, by1: 16'sd100},
                    1'b1, miss};
        // All zero.
        rows[5] = '{'0, 1'b1, miss};
        // A vertical, B horizontal, crossing at (5, 3).
        rows[6] = '{'{ax0: 16'sd5, ay0: -16'sd10, ax1: 16'sd5, ay1: 16'sd10,
                      bx0: -16'sd10, by0: 16'sd3, bx1: 16'sd10, by1: 16'sd3},
                    1'b1, '{1'b1, 16'sd5, 16'sd3}};
        // Lines cross outside the segments.
        rows[7] = '{'{ax0: 16'sd0, ay0: 16'sd900, ax1: 16'sd100, ay1: 16'sd800,
                      bx0: -16'sd100, by0: -16'sd100, bx1: 16'sd100, by1: 16'sd100},
                    1'b1, miss};
        // Extremes: diagonals of the full square cross at (-1, -1).
        rows[8] = '{'{16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff,
                      16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000}, 1'b0, miss};
        rows[9] = '{'{16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000,
                      16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff}, 1'b0, miss};
        // Nearly parallel pair that meets at an end point.
        rows[10] = '{'{16'sd1, 16'sh7fff, 16'sd0, 16'sh8000,
                       16'sd0, 16'sh7fff, 16'sd0, 16'sh8000}, 1'b0, miss};
        // Truncation toward zero with negative quotients.
        rows[11] = '{'{-16'sd2, 16'sd3, 16'sd5, -16'sd7,
                       -16'sd1, -16'sd4, 16'sd3, 16'sd6}, 1'b0, miss};
        rows[12] = '{'{16'sh7fff, 16'sd0, 16'sh8000, 16'sd1,
                       16'sd0, 16'sh7fff, 16'sd1, 16'sh8000}, 1'b0, miss};
        rows[13] = '{'{16'shffff, 16'shffff, 16'shffff, 16'shffff,
                       16'shffff, 16'shffff, 16'shffff, 16'shffff}, 1'b1, miss};

        foreach (rows[i]) begin
            if (rows[i].known) begin
                got = intersect_segments(rows[i].pair);
                if (got != rows[i].want) begin
                    $display("%0t: row %0d predictor expected %p actual %p", $time, i,
                             rows[i].want, got);
                    errors++;
                end
            end
            send_pair(rows[i].pair);
        end

        n = 0;
        while (n < 1900) begin
            // Hold off once until every result has drained.
            if (n == 900) begin
                s_tvalid <= 1'b0;
                @(negedge aclk);
                while (pending_crossings.size() != 0) @(negedge aclk);
            end
            p = rand_pair();
            send_pair(p);
            n++;
        end
        s_tvalid <= 1'b0;

        while (pending_crossings.size() != 0) @(posedge aclk);
        repeat (2 * LATENCY) @(posedge aclk);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial begin
        #2000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

// File: segment_intersection_point_unit.f
rtl/sipu_pkg.sv
rtl/segment_intersection_point_unit.sv
sim/tb_top.sv
